// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is active
`define GIVM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("givm assertion failed");

// clocked assertion that is also checked during reset
`define GIVM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("givm assertion failed");

`endif

// ===== rtl/givm_pkg.sv =====
// package: widths, constants and state type of the grouped weighted mean block
`default_nettype none

package givm_pkg;

    // field widths
    localparam int GS_W   = 7;
    localparam int RUN_W  = 20;
    localparam int VAL_W  = 24;
    localparam int ERR_W  = 16;

    // weight floor(2^32 / e^2) needs 33 bits, value * weight fits in 57 signed bits
    localparam int W_W    = 33;
    localparam int PROD_W = 57;

    // square root of a 33 bit quotient: 17 two-bit digits
    localparam int SQ_STEPS  = 17;
    localparam int ROOT_W    = 17;
    localparam int SQ_REM_W  = 18;
    localparam int SQ_CUR_W  = 20;

    // dividend 2^32 for both reciprocal divisions
    localparam logic [W_W-1:0] TWO_POW_32 = 33'h1_0000_0000;

    // saturated error output
    localparam logic [ERR_W-1:0] ERR_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WDIV,
        ST_MUL,
        ST_ACC,
        ST_MLOAD,
        ST_MDIV,
        ST_ELOAD,
        ST_EDIV,
        ST_SLOAD,
        ST_SQRT,
        ST_OUT
    } givm_state_t;

endpackage

`default_nettype wire

// ===== rtl/givm_if.sv =====
// channel interfaces: measurement input and group result output
`default_nettype none

interface givm_meas_if import givm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RUN_W-1:0]        run_number;
    logic signed [VAL_W-1:0] value;
    logic [ERR_W-1:0]        error;
    logic                    end_of_list;

    modport source (
        output valid, run_number, value, error, end_of_list,
        input  ready
    );
    modport sink (
        input  valid, run_number, value, error, end_of_list,
        output ready
    );
endinterface

interface givm_res_if import givm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RUN_W-1:0]        first_run;
    logic signed [VAL_W-1:0] mean;
    logic [ERR_W-1:0]        mean_error;

    modport source (
        output valid, first_run, mean, mean_error,
        input  ready
    );
    modport sink (
        input  valid, first_run, mean, mean_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/grouped_inverse_variance_mean_top.sv =====
// top level: grouped inverse-variance weighted mean with a bit-serial divider and root unit
// each measurement runs from acceptance through the bit-serial divider for floor(2^32/e^2),
// then multiply and accumulate, before the next one can be accepted
// a closing measurement adds a mean division of NUM_W bits and a 33-bit reciprocal division
// on the same divider shift logic, then a 17-step square root
// the result sits in an output register; new measurements are accepted while it waits
// reset is asynchronous: accumulators and count clear, group_size returns to 1, no sweep
`default_nettype none

module grouped_inverse_variance_mean_top
    import givm_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    givm_meas_if.sink            meas,
    givm_res_if.source           result,
    input  wire logic            cfg_we,
    input  wire logic [GS_W-1:0] cfg_wdata
);

    // sizes that follow from the largest group
    localparam int SIZE_MAX = (MAX_GROUP < 127) ? MAX_GROUP : 127;
    localparam int CNT_W    = $clog2(SIZE_MAX + 1);
    localparam int WS_W     = W_W + $clog2(SIZE_MAX);
    localparam int WV_W     = PROD_W + $clog2(SIZE_MAX);
    localparam int NUM_W    = WV_W;
    localparam int REM_W    = WS_W + 1;
    localparam int DCNT_W   = $clog2(NUM_W);
    localparam int SCNT_W   = $clog2(SQ_STEPS);

    localparam logic [GS_W-1:0]   SIZE_CAP   = GS_W'(SIZE_MAX);
    localparam logic [DCNT_W-1:0] DCNT_WLAST = DCNT_W'(W_W - 1);
    localparam logic [DCNT_W-1:0] DCNT_MLAST = DCNT_W'(NUM_W - 1);
    localparam logic [SCNT_W-1:0] SCNT_LAST  = SCNT_W'(SQ_STEPS - 1);
    localparam logic [NUM_W-1:0]  RECIP_NUM  = {TWO_POW_32, (NUM_W - W_W)'(0)};

    // control registers
    givm_state_t        state_reg, state_next;
    logic [GS_W-1:0]    group_size_reg, group_size_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [WV_W-1:0] wvs_reg, wvs_next;
    logic [WS_W-1:0]    ws_reg, ws_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [SCNT_W-1:0]  scnt_reg, scnt_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [RUN_W-1:0]         first_run_reg, first_run_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic [VAL_W-1:0]         mean_reg, mean_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [WS_W-1:0]          rem_reg, rem_next;
    logic [WS_W-1:0]          den_reg, den_next;
    logic [2*SQ_STEPS-1:0]    sq_x_reg, sq_x_next;
    logic [SQ_REM_W-1:0]      sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [RUN_W-1:0]         out_run_reg, out_run_next;
    logic [VAL_W-1:0]         out_mean_reg, out_mean_next;
    logic [ERR_W-1:0]         out_err_reg, out_err_next;

    // combinational helpers
    logic                  accept;
    logic                  in_ready;
    logic                  out_load;
    logic [ERR_W-1:0]      err_fix;
    logic [2*ERR_W-1:0]    err_sq;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      den_ext;
    logic                  div_ge;
    logic [WS_W-1:0]       div_rem;
    logic [NUM_W-1:0]      div_num;
    logic [SQ_CUR_W-1:0]   sq_cur;
    logic [SQ_CUR_W-1:0]   sq_trial;
    logic                  sq_ge;
    logic [GS_W-1:0]       size_eff;
    logic                  group_close;
    logic [W_W-1:0]        weight;

    // squared error, a zero code counts as one
    assign err_fix = (meas.error == '0) ? ERR_W'(1) : meas.error;
    assign err_sq  = (2*ERR_W)'(err_fix) * (2*ERR_W)'(err_fix);

    // one restoring division step, quotient bits shift into the dividend register
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign den_ext = {1'b0, den_reg};
    assign div_ge  = (rem_sh >= den_ext);
    assign div_rem = div_ge ? WS_W'(rem_sh - den_ext) : rem_sh[WS_W-1:0];
    assign div_num = {num_reg[NUM_W-2:0], div_ge};

    // one square root digit step
    assign sq_cur   = {sq_rem_reg, sq_x_reg[2*SQ_STEPS-1 -: 2]};
    assign sq_trial = SQ_CUR_W'({root_reg, 2'b01});
    assign sq_ge    = (sq_cur >= sq_trial);

    // effective group size: zero means one, large values saturate
    always_comb
    begin
        if (group_size_reg == '0)
        begin
            size_eff = GS_W'(1);
        end
        else if (group_size_reg > SIZE_CAP)
        begin
            size_eff = SIZE_CAP;
        end
        else
        begin
            size_eff = group_size_reg;
        end
    end

    assign group_close = (GS_W'(cnt_reg) >= size_eff) || last_reg;
    assign weight      = num_reg[W_W-1:0];

    // handshake outputs
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = meas.valid && in_ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    assign meas.ready        = in_ready;
    assign result.valid      = out_valid_reg;
    assign result.first_run  = out_run_reg;
    assign result.mean       = out_mean_reg;
    assign result.mean_error = out_err_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas.valid)
                begin
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                if (dcnt_reg == DCNT_WLAST)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = group_close ? ST_MLOAD : ST_IDLE;
            ST_MLOAD: state_next = ST_MDIV;
            ST_MDIV:
            begin
                if (dcnt_reg == DCNT_MLAST)
                begin
                    state_next = ST_ELOAD;
                end
            end
            ST_ELOAD: state_next = ST_EDIV;
            ST_EDIV:
            begin
                if (dcnt_reg == DCNT_WLAST)
                begin
                    state_next = ST_SLOAD;
                end
            end
            ST_SLOAD: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (scnt_reg == SCNT_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        group_size_next = cfg_we ? cfg_wdata : group_size_reg;
        cnt_next        = cnt_reg;
        wvs_next        = wvs_reg;
        ws_next         = ws_reg;
        dcnt_next       = dcnt_reg;
        scnt_next       = scnt_reg;
        first_run_next  = first_run_reg;
        run_next        = run_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        mean_next       = mean_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        sq_x_next       = sq_x_reg;
        sq_rem_next     = sq_rem_reg;
        root_next       = root_reg;
        out_run_next    = out_run_reg;
        out_mean_next   = out_mean_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = result.ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // capture the transaction and start the weight division
                if (accept)
                begin
                    run_next  = meas.run_number;
                    val_next  = meas.value;
                    last_next = meas.end_of_list;
                    den_next  = WS_W'(err_sq);
                    num_next  = RECIP_NUM;
                    rem_next  = '0;
                    dcnt_next = '0;
                end
            end
            ST_WDIV, ST_MDIV, ST_EDIV:
            begin
                num_next  = div_num;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg + 1'b1;
            end
            ST_MUL:
            begin
                // weighted value and weight sum
                prod_next = $signed(PROD_W'(val_reg)) * $signed(PROD_W'({1'b0, weight}));
                ws_next   = ws_reg + WS_W'(weight);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    first_run_next = run_reg;
                end
            end
            ST_ACC:
            begin
                wvs_next = wvs_reg + WV_W'(prod_reg);
            end
            ST_MLOAD:
            begin
                // divide the magnitude, fix the sign afterwards
                neg_next  = wvs_reg[WV_W-1];
                num_next  = wvs_reg[WV_W-1] ? NUM_W'($unsigned(-wvs_reg))
                                            : NUM_W'($unsigned(wvs_reg));
                den_next  = ws_reg;
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_ELOAD:
            begin
                mean_next = neg_reg ? (~num_reg[VAL_W-1:0] + 1'b1) : num_reg[VAL_W-1:0];
                num_next  = RECIP_NUM;
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_SLOAD:
            begin
                sq_x_next   = {1'b0, num_reg[W_W-1:0]};
                sq_rem_next = '0;
                root_next   = '0;
                scnt_next   = '0;
            end
            ST_SQRT:
            begin
                sq_x_next   = {sq_x_reg[2*SQ_STEPS-3:0], 2'b00};
                sq_rem_next = SQ_REM_W'(sq_ge ? (sq_cur - sq_trial) : sq_cur);
                root_next   = {root_reg[ROOT_W-2:0], sq_ge};
                scnt_next   = scnt_reg + 1'b1;
            end
            ST_OUT:
            begin
                // publish the result and clear the group
                if (out_load)
                begin
                    out_run_next   = first_run_reg;
                    out_mean_next  = mean_reg;
                    out_err_next   = root_reg[ROOT_W-1] ? ERR_MAX : root_reg[ERR_W-1:0];
                    out_valid_next = 1'b1;
                    wvs_next       = '0;
                    ws_next        = '0;
                    cnt_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            group_size_reg <= GS_W'(1);
            cnt_reg        <= '0;
            wvs_reg        <= '0;
            ws_reg         <= '0;
            dcnt_reg       <= '0;
            scnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            group_size_reg <= group_size_next;
            cnt_reg        <= cnt_next;
            wvs_reg        <= wvs_next;
            ws_reg         <= ws_next;
            dcnt_reg       <= dcnt_next;
            scnt_reg       <= scnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_run_reg <= first_run_next;
        run_reg       <= run_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        mean_reg      <= mean_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        sq_x_reg      <= sq_x_next;
        sq_rem_reg    <= sq_rem_next;
        root_reg      <= root_next;
        out_run_reg   <= out_run_next;
        out_mean_reg  <= out_mean_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire

// ===== rtl/givm_chk.sv =====
// port-level checker for the grouped weighted mean block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module givm_chk
    import givm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             meas_valid,
    input wire logic             meas_ready,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [RUN_W-1:0] res_first_run,
    input wire logic [VAL_W-1:0] res_mean,
    input wire logic [ERR_W-1:0] res_mean_error
);

    // a stalled result keeps its payload
    `GIVM_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_first_run) && $stable(res_mean) && $stable(res_mean_error))

    // the unit is busy right after taking a measurement
    `GIVM_ASSERT(a_busy_after_accept, clk, rst_n, meas_valid && meas_ready |=> !meas_ready)

    // a new result only appears as the unit leaves its busy phase
    `GIVM_ASSERT(a_res_after_busy, clk, rst_n, $rose(res_valid) |-> $past(!meas_ready))

    // no result during reset
    `GIVM_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !res_valid)

endmodule

bind grouped_inverse_variance_mean_top givm_chk u_givm_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .meas_valid     (meas.valid),
    .meas_ready     (meas.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_first_run  (result.first_run),
    .res_mean       (result.mean),
    .res_mean_error (result.mean_error)
);

`default_nettype wire

// ===== dv/tb_grouped_inverse_variance_mean_top.sv =====
// testbench for the grouped inverse-variance weighted mean block: directed and random traffic
`default_nettype none

module tb_grouped_inverse_variance_mean_top;
    timeunit 1ns;
    timeprecision 1ps;

    import givm_pkg::*;

    localparam int MAX_GROUP_SIZE = 64;
    // settle time long enough for one measurement plus a full group close
    localparam int SETTLE_CYCLES  = 200;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [RUN_W-1:0]        first_run;
        logic signed [VAL_W-1:0] mean;
        logic [ERR_W-1:0]        mean_error;
    } group_result_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [GS_W-1:0] cfg_wdata;

    givm_meas_if meas_ch ();
    givm_res_if  res_ch ();

    grouped_inverse_variance_mean_top #(
        .MAX_GROUP (MAX_GROUP_SIZE)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas_ch.sink),
        .result    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted state of the block
    logic [GS_W-1:0]  model_group_size = 1;
    longint           model_value_weight_sum = 0;
    logic [39:0]      model_weight_sum = '0;
    logic [GS_W-1:0]  model_count = '0;
    logic [RUN_W-1:0] model_first_run = '0;

    group_result_t group_results_due[$];
    group_result_t expected_group;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int cycle_count        = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_grouped_inverse_variance_mean_top failed");
            $finish;
        end
    end

    // result receiver with random stalls
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // compare each result transaction with the oldest predicted group
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (group_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: first_run %h mean %h mean_error %h",
                             res_ch.first_run, res_ch.mean, res_ch.mean_error);
            end
            else
            begin
                expected_group = group_results_due.pop_front();
                if (res_ch.first_run !== expected_group.first_run ||
                    res_ch.mean !== expected_group.mean ||
                    res_ch.mean_error !== expected_group.mean_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp run %h mean %h err %h, got run %h mean %h err %h",
                                 expected_group.first_run, expected_group.mean,
                                 expected_group.mean_error, res_ch.first_run, res_ch.mean,
                                 res_ch.mean_error);
                end
            end
        end
    end

    // fold one accepted measurement into the predicted group, queue the mean when it closes
    task automatic accumulate_measurement(input logic [RUN_W-1:0] run,
                                          input logic signed [VAL_W-1:0] val,
                                          input logic [ERR_W-1:0] err,
                                          input logic eol);
        logic [63:0]   err_sq;
        logic [63:0]   weight;
        logic [63:0]   recip;
        logic [63:0]   root;
        logic [63:0]   trial;
        int            eff_size;
        longint        quotient;
        group_result_t closed;
        begin
            // a zero error counts as the smallest code
            err_sq = (err == 0) ? 64'd1 : 64'(err) * 64'(err);
            weight = 64'h1_0000_0000 / err_sq;

            eff_size = (model_group_size == 0) ? 1 : int'(model_group_size);
            if (eff_size > MAX_GROUP_SIZE)
                eff_size = MAX_GROUP_SIZE;

            if (model_count == 0)
                model_first_run = run;
            model_value_weight_sum += longint'(val) * longint'(weight);
            model_weight_sum += weight[39:0];
            model_count = model_count + 1'b1;

            if (int'(model_count) >= eff_size || eol)
            begin
                // signed division truncates toward zero
                quotient = model_value_weight_sum / longint'({24'd0, model_weight_sum});
                recip = 64'h1_0000_0000 / {24'd0, model_weight_sum};
                // integer square root, one bit at a time
                root = '0;
                for (int b = 16; b >= 0; b--)
                begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= recip)
                        root = trial;
                end
                if (root > 64'd65535)
                    root = 64'd65535;

                closed.first_run  = model_first_run;
                closed.mean       = quotient[VAL_W-1:0];
                closed.mean_error = root[ERR_W-1:0];
                group_results_due = {group_results_due, closed};

                model_value_weight_sum = 0;
                model_weight_sum = '0;
                model_count = '0;
            end
        end
    endtask

    // one measurement transaction, entered and left at a falling edge
    task automatic send_measurement(input logic [RUN_W-1:0] run,
                                    input logic signed [VAL_W-1:0] val,
                                    input logic [ERR_W-1:0] err,
                                    input logic eol);
        begin
            while ($urandom_range(0, 99) < sender_idle_pct)
            begin
                meas_ch.valid = 1'b0;
                @(negedge clk);
            end
            meas_ch.valid       = 1'b1;
            meas_ch.run_number  = run;
            meas_ch.value       = val;
            meas_ch.error       = err;
            meas_ch.end_of_list = eol;
            @(posedge clk);
            while (!meas_ch.ready)
                @(posedge clk);
            accumulate_measurement(run, val, err, eol);
            @(negedge clk);
        end
    endtask

    // measurement with values biased toward the edges
    task automatic send_random_measurement(input int eol_pct);
        logic [RUN_W-1:0]        run;
        logic signed [VAL_W-1:0] val;
        logic [ERR_W-1:0]        err;
        int                      pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                run = '0;
            else if (pick < 10)
                run = '1;
            else
                run = RUN_W'($urandom());

            pick = $urandom_range(0, 99);
            if (pick < 10)
                val = 24'sh7FFFFF;
            else if (pick < 20)
                val = 24'sh800000;
            else if (pick < 25)
                val = '0;
            else if (pick < 35)
                val = VAL_W'($urandom_range(0, 64) - 32);
            else
                val = VAL_W'($urandom());

            pick = $urandom_range(0, 99);
            if (pick < 8)
                err = '0;
            else if (pick < 18)
                err = 16'd1;
            else if (pick < 28)
                err = '1;
            else if (pick < 48)
                err = ERR_W'($urandom_range(2, 16));
            else if (pick < 63)
                err = ERR_W'($urandom_range(128, 1024));
            else
                err = ERR_W'($urandom());

            send_measurement(run, val, err, $urandom_range(0, 99) < eol_pct);
        end
    endtask

    // wait for every predicted group, then let the block finish any open measurement
    task automatic wait_until_idle();
        begin
            meas_ch.valid = 1'b0;
            while (group_results_due.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // register write, only while the block is idle
    task automatic write_group_size(input logic [GS_W-1:0] size);
        begin
            cfg_we    = 1'b1;
            cfg_wdata = size;
            @(negedge clk);
            cfg_we = 1'b0;
            model_group_size = size;
        end
    endtask

    // field extremes with single-item groups
    task automatic test_field_extremes();
        begin
            send_measurement('0, 24'sh7FFFFF, 16'd1, 1'b0);
            send_measurement('1, 24'sh800000, 16'hFFFF, 1'b1);
            send_measurement(20'h5A5A5, 24'sh000000, 16'h0100, 1'b0);
            send_measurement(20'hA5A5A, -24'sd1, 16'h8000, 1'b0);
            send_measurement(20'h00001, 24'sh000001, 16'h00FF, 1'b1);
            wait_until_idle();
        end
    endtask

    // zero error takes the largest weight
    task automatic test_zero_error();
        begin
            write_group_size(7'd2);
            send_measurement(20'h12345, -24'sd5, 16'd0, 1'b0);
            send_measurement(20'h12346, 24'sh7FFFFF, 16'd3, 1'b0);
            wait_until_idle();
        end
    endtask

    // size zero acts as one, sizes above the maximum saturate
    task automatic test_group_size_limits();
        begin
            write_group_size(7'd0);
            send_measurement(20'h00010, 24'sh123456, 16'h0200, 1'b0);
            send_measurement(20'h00011, 24'sh800000, 16'd0, 1'b0);
            wait_until_idle();
            write_group_size(7'd127);
            send_measurement(20'h00020, 24'sh7FFFFF, 16'd1, 1'b0);
            send_measurement(20'h00021, 24'sh800000, 16'd1, 1'b0);
            send_measurement(20'h00022, 24'sh000100, 16'hFFFF, 1'b1);
            wait_until_idle();
            write_group_size(7'd64);
            send_measurement(20'h00030, 24'sh400000, 16'd7, 1'b0);
            send_measurement(20'h00031, -24'sd100, 16'd9, 1'b1);
            wait_until_idle();
        end
    endtask

    // shrinking the size of an open group closes it on the next measurement
    task automatic test_size_change_mid_group();
        begin
            write_group_size(7'd5);
            send_measurement(20'h00100, 24'sh010000, 16'h0080, 1'b0);
            send_measurement(20'h00101, 24'sh020000, 16'h0100, 1'b0);
            send_measurement(20'h00102, -24'sh030000, 16'h0040, 1'b0);
            wait_until_idle();
            write_group_size(7'd2);
            send_measurement(20'h00103, 24'sh000007, 16'h0010, 1'b0);
            send_measurement(20'h00104, 24'sh7FFFF0, 16'h0001, 1'b0);
            send_measurement(20'h00105, 24'sh800010, 16'h0002, 1'b0);
            wait_until_idle();
        end
    endtask

    // end of list on a full group and on a partial one
    task automatic test_end_of_list();
        begin
            write_group_size(7'd3);
            send_measurement(20'h00200, 24'sh000300, 16'h0300, 1'b0);
            send_measurement(20'h00201, 24'sh000301, 16'h0301, 1'b0);
            send_measurement(20'h00202, 24'sh000302, 16'h0302, 1'b1);
            wait_until_idle();
            write_group_size(7'd4);
            send_measurement(20'h00203, -24'sd77, 16'h0011, 1'b0);
            send_measurement(20'h00204, 24'sd77, 16'h0022, 1'b1);
            wait_until_idle();
        end
    endtask

    // random measurements over several group sizes with one idle pattern
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [GS_W-1:0] sizes[5];
        int              counts[5];
        begin
            sender_idle_pct    = idle_pct;
            receiver_stall_pct = stall_pct;
            sizes[0] = 7'd1;
            sizes[1] = 7'd64;
            sizes[2] = 7'd127;
            sizes[3] = 7'd0;
            sizes[4] = GS_W'($urandom_range(2, 70));
            counts[0] = 50;
            counts[1] = 130;
            counts[2] = 130;
            counts[3] = 50;
            counts[4] = 80;
            for (int s = 0; s < 5; s++)
            begin
                write_group_size(sizes[s]);
                repeat (counts[s]) send_random_measurement(2);
                wait_until_idle();
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        meas_ch.valid       = 1'b0;
        meas_ch.run_number  = '0;
        meas_ch.value       = '0;
        meas_ch.error       = '0;
        meas_ch.end_of_list = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_zero_error();
        test_group_size_limits();
        test_size_change_mid_group();
        test_end_of_list();

        test_random_traffic(0, 0);
        test_random_traffic(57, 0);
        test_random_traffic(0, 57);
        test_random_traffic(34, 34);

        wait_until_idle();
        if (mismatch_count == 0 && group_results_due.size() == 0)
            $display("tb_grouped_inverse_variance_mean_top passed");
        else
            $display("tb_grouped_inverse_variance_mean_top failed");
        $finish;
    end

endmodule

`default_nettype wire
